// ----- hw/rtl/kms_pkg.sv -----
// shared constants and types of the key matrix scanner
package kms_pkg;

  // matrix geometry
  localparam int unsigned ROW_COUNT    = 5;
  localparam int unsigned COLUMN_COUNT = 4;
  localparam int unsigned BUTTON_COUNT = 2;

  localparam int unsigned MATRIX_KEYS = ROW_COUNT * COLUMN_COUNT;
  localparam int unsigned KEY_COUNT   = MATRIX_KEYS + BUTTON_COUNT;

  // port field widths
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned BUTTON_W = 2;
  localparam int unsigned DRIVE_W  = 4;
  localparam int unsigned KEY_IDX_W = 5;
  localparam int unsigned TICK_W   = 16;

  // internal widths
  localparam int unsigned ROW_EXT_W = (ROW_COUNT > ROW_W) ? ROW_COUNT : ROW_W;
  localparam int unsigned COL_W     = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
  localparam int unsigned WALK_W    = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int unsigned WALK_EXT_W = (WALK_W > KEY_IDX_W) ? WALK_W : KEY_IDX_W;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_INTERVAL  = 2'd1;

  localparam logic [TICK_W-1:0] SETTLE_RESET   = 16'd1;
  localparam logic [TICK_W-1:0] INTERVAL_RESET = 16'd10;

  // scan phases, one-hot
  typedef enum logic [3:0] {
    PH_COLUMN = 4'b0001,
    PH_GAP    = 4'b0010,
    PH_WALK   = 4'b0100,
    PH_IDLE   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [TICK_W-1:0] settle_ticks;
    logic [TICK_W-1:0] scan_interval_ticks;
  } cfg_t;

  typedef struct packed {
    logic [DRIVE_W-1:0]   column_drive;
    logic                 press_valid;
    logic [KEY_IDX_W-1:0] key_index;
  } result_t;

endpackage

// ----- hw/rtl/kms_cfg_regs.sv -----
// configuration registers of the key matrix scanner
module kms_cfg_regs import kms_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TICK_W-1:0]    cfg_data_i,
  output logic                 cfg_ready_o,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SETTLE_TICKS:  cfg_d.settle_ticks        = cfg_data_i;
        CFG_SCAN_INTERVAL: cfg_d.scan_interval_ticks = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ticks        <= SETTLE_RESET;
      cfg_q.scan_interval_ticks <= INTERVAL_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/kms_scan_core.sv -----
// scan sequencer: key state, phase counters and per-tick result logic
module kms_scan_core import kms_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [ROW_W-1:0]    rows_i,
  input  logic [BUTTON_W-1:0] buttons_i,
  input  cfg_t                cfg_i,
  output result_t             result_o
);

  phase_e                 phase_q, phase_d;
  logic [KEY_COUNT-1:0]   cur_q, cur_d;
  logic [KEY_COUNT-1:0]   prev_q, prev_d;
  logic [COL_W-1:0]       col_q, col_d;
  logic [TICK_W-1:0]      wait_q, wait_d;
  logic [WALK_W-1:0]      walk_q, walk_d;
  logic                   primed_q, primed_d;

  logic [TICK_W:0]        wait_inc;
  logic                   settle_done;
  logic                   idle_done;
  logic [ROW_EXT_W-1:0]   rows_ext;
  logic [WALK_EXT_W-1:0]  walk_ext;
  logic                   interval_zero;

  assign wait_inc      = {1'b0, wait_q} + 1'b1;
  // a settle time of zero behaves as one
  assign settle_done   = (cfg_i.settle_ticks == '0) ||
                         (wait_inc >= {1'b0, cfg_i.settle_ticks});
  assign idle_done     = wait_inc >= {1'b0, cfg_i.scan_interval_ticks};
  assign rows_ext      = ROW_EXT_W'(rows_i);
  assign walk_ext      = WALK_EXT_W'(walk_q);
  assign interval_zero = cfg_i.scan_interval_ticks == '0;

  always_comb begin
    phase_d  = phase_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    col_d    = col_q;
    wait_d   = wait_q;
    walk_d   = walk_q;
    primed_d = primed_q;
    result_o = '0;

    case (phase_q)
      PH_GAP: begin
        if (settle_done) begin
          // buttons are active low
          for (int b = 0; b < BUTTON_COUNT; b++) begin
            cur_d[MATRIX_KEYS + b] = ~buttons_i[b];
          end
          if (!primed_q) begin
            primed_d = 1'b1;
            prev_d   = cur_d;
            col_d    = '0;
            wait_d   = '0;
            walk_d   = '0;
            phase_d  = interval_zero ? PH_COLUMN : PH_IDLE;
          end else begin
            phase_d = PH_WALK;
            walk_d  = '0;
            wait_d  = '0;
          end
        end else begin
          wait_d = wait_inc[TICK_W-1:0];
        end
      end

      PH_WALK: begin
        if (cur_q[walk_q] && !prev_q[walk_q]) begin
          result_o.press_valid = 1'b1;
          result_o.key_index   = walk_ext[KEY_IDX_W-1:0];
        end
        if (walk_q == WALK_W'(KEY_COUNT - 1)) begin
          prev_d  = cur_q;
          col_d   = '0;
          wait_d  = '0;
          walk_d  = '0;
          phase_d = interval_zero ? PH_COLUMN : PH_IDLE;
        end else begin
          walk_d = walk_q + 1'b1;
        end
      end

      PH_IDLE: begin
        if (idle_done) begin
          phase_d = PH_COLUMN;
          col_d   = '0;
          wait_d  = '0;
        end else begin
          wait_d = wait_inc[TICK_W-1:0];
        end
      end

      default: begin
        // column phase, also taken for any unused phase code
        phase_d = PH_COLUMN;
        for (int c = 0; c < DRIVE_W; c++) begin
          if (c < COLUMN_COUNT) begin
            result_o.column_drive[c] = (col_q == COL_W'(c));
          end
        end
        if (settle_done) begin
          for (int r = 0; r < ROW_COUNT; r++) begin
            for (int c = 0; c < COLUMN_COUNT; c++) begin
              if (col_q == COL_W'(c)) begin
                cur_d[r * COLUMN_COUNT + c] = (r < ROW_W) ? rows_ext[r] : 1'b0;
              end
            end
          end
          wait_d = '0;
          if (col_q == COL_W'(COLUMN_COUNT - 1)) begin
            col_d   = '0;
            phase_d = PH_GAP;
          end else begin
            col_d = col_q + 1'b1;
          end
        end else begin
          wait_d = wait_inc[TICK_W-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_COLUMN;
      cur_q    <= '0;
      prev_q   <= '0;
      col_q    <= '0;
      wait_q   <= '0;
      walk_q   <= '0;
      primed_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      cur_q    <= cur_d;
      prev_q   <= prev_d;
      col_q    <= col_d;
      wait_q   <= wait_d;
      walk_q   <= walk_d;
      primed_q <= primed_d;
    end
  end

endmodule

// ----- hw/rtl/key_matrix_scanner_unit.sv -----
// top level of the key matrix scanner: input register, scan core, result register
//
// each input item is one timebase tick carrying the raw row levels and the
// active-low button levels; each tick yields exactly one result item with
// the column drive, a press flag and the pressed key index
// channels: input (in_valid_i / in_stall_o), result (out_valid_o /
// out_stall_i), and a config write port (cfg_valid_i / cfg_ready_o) that
// selects settle_ticks (index 0) or scan_interval_ticks (index 1)
// path: an accepted item waits in the input register, and its result is
// written to the result register when the scan core steps on it
// throughput: one item per cycle while the receiver does not stall, set by the
// combinational scan core step between the input register and the result register
// reset: scan restarts at the first column, key state cleared, first scan
// only primes the previous keys; settle 1, interval 10
// receiver stall: the result register holds; the input register holds its
// item and in_stall_o rises only while both stages are full
// config writes are always ready and must come with no item in flight
module key_matrix_scanner_unit import kms_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // tick items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ROW_W-1:0]     row_levels_i,
  input  logic [BUTTON_W-1:0]  button_levels_i,
  // result items
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DRIVE_W-1:0]   column_drive_o,
  output logic                 press_valid_o,
  output logic [KEY_IDX_W-1:0] key_index_o,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TICK_W-1:0]    cfg_data_i
);

  cfg_t                cfg;
  result_t             result;
  result_t             res_q;

  // input register and result valid flag
  logic                in_vld_q, in_vld_d;
  logic [ROW_W-1:0]    rows_q;
  logic [BUTTON_W-1:0] buttons_q;
  logic                out_vld_q, out_vld_d;

  logic                out_free;
  logic                step;
  logic                in_take;

  // result slot frees up when empty or being taken this cycle
  assign out_free   = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      rows_q    <= row_levels_i;
      buttons_q <= button_levels_i;
    end
    if (step) begin
      res_q <= result;
    end
  end

  kms_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  kms_scan_core u_scan_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rows_i    (rows_q),
    .buttons_i (buttons_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  assign out_valid_o    = out_vld_q;
  assign column_drive_o = res_q.column_drive;
  assign press_valid_o  = res_q.press_valid;
  assign key_index_o    = res_q.key_index;

endmodule
